// ===== rtl/skalk_pkg.sv =====
// Shared types and constants for the three-axis scalar Kalman filter.
// Used by skalk_mac, skalk_div and scalar_kalman_three_axis_core.
package skalk_pkg;

  // Field widths
  localparam int DATA_W    = 32;
  localparam int NOISE_W   = 24;
  localparam int GAIN_BITS = 16;
  localparam int GAIN_W    = GAIN_BITS + 1;
  localparam int MAX_AXES  = 3;

  // Parameter defaults
  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_AXES      = 3;

  // Gain of exactly one
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_DEV   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST   = CFG_IDX_W'(3);

  // Register reset values
  localparam logic [NOISE_W-1:0] RST_PROC_NOISE = NOISE_W'(3277);
  localparam logic [NOISE_W-1:0] RST_MEAS_NOISE = NOISE_W'(6554);
  localparam logic [NOISE_W-1:0] RST_INIT_DEV   = NOISE_W'(32768);
  localparam logic [DATA_W-1:0]  RST_INIT_EST   = DATA_W'(65536);

  // Control of one bit-serial multiply lane
  typedef struct packed {
    logic start;
    logic step;
  } mac_ctl_t;

  // Control of the restoring divider
  typedef struct packed {
    logic start;
    logic step;
    logic first;
  } div_ctl_t;

endpackage

// ===== rtl/skalk_mac.sv =====
// Bit-serial shift-add multiply lane: signed multiplicand, unsigned multiplier,
// one multiplier bit per step, LSB first. Depends on skalk_pkg.
module skalk_mac #(
  parameter int MW = 33,
  parameter int NB = 17
) (
  input  logic                    clk,
  input  skalk_pkg::mac_ctl_t     ctl,
  input  logic signed [MW-1:0]    a,
  input  logic        [NB-1:0]    b,
  output logic signed [MW+NB-1:0] prod
);
  import skalk_pkg::*;

  logic signed [MW-1:0] a_q;
  logic signed [MW-1:0] hi;
  logic        [NB-1:0] b_q;
  logic        [NB-1:0] lo;
  logic        [MW:0]   sum;

  // add the multiplicand when the current multiplier bit is set
  assign sum = {hi[MW-1], hi} + (b_q[0] ? {a_q[MW-1], a_q} : {(MW+1){1'b0}});

  // load operands, then shift the partial product right one bit per step
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_q <= a;
      b_q <= b;
      hi  <= '0;
      lo  <= '0;
    end else if (ctl.step) begin
      hi  <= sum[MW:1];
      lo  <= {sum[0], lo[NB-1:1]};
      b_q <= b_q >> 1;
    end
  end

  assign prod = {hi, lo};

endmodule

// ===== rtl/skalk_div.sv =====
// Restoring divider for the gain: floor(num * 2^16 / den), one quotient bit
// per step, 17 steps. A zero denominator gives zero. Depends on skalk_pkg.
module skalk_div (
  input  logic                            clk,
  input  skalk_pkg::div_ctl_t             ctl,
  input  logic [skalk_pkg::DATA_W-1:0]    num,
  input  logic [skalk_pkg::DATA_W:0]      den,
  output logic [skalk_pkg::GAIN_W-1:0]    quo
);
  import skalk_pkg::*;

  localparam int DW = DATA_W + 1;

  logic [DW-1:0]     den_q;
  logic [DW-1:0]     rem_q;
  logic [GAIN_W-1:0] q_q;
  logic              zero_q;
  logic [DW:0]       trial;
  logic [DW+1:0]     diff;
  logic              ge;

  // the first step tests the integer bit without a shift
  assign trial = ctl.first ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign ge    = ~diff[DW+1];

  // load operands, then subtract where the trial remainder allows
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      den_q  <= den;
      rem_q  <= {1'b0, num};
      q_q    <= '0;
      zero_q <= (den == '0);
    end else if (ctl.step) begin
      rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q_q    <= {q_q[GAIN_W-2:0], ge};
    end
  end

  assign quo = zero_q ? '0 : q_q;

endmodule

// ===== rtl/scalar_kalman_three_axis_core.sv =====
// Three-axis scalar Kalman filter with shared variance and gain.
// Each word runs a 17-step serial divide followed by a 17-step serial
// multiply; restart adds a 24-step serial square of initial_deviation first.
// A new word is accepted only while idle. The output register lets the
// next word start while a result waits. Reset loads register defaults and
// the matching estimate and variance (19661 at 16 fraction bits).
module scalar_kalman_three_axis_core #(
  parameter int FRAC_BITS = skalk_pkg::DEF_FRAC_BITS,
  parameter int AXES      = skalk_pkg::DEF_AXES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [skalk_pkg::DATA_W-1:0]  sample_x,
  input  logic signed [skalk_pkg::DATA_W-1:0]  sample_y,
  input  logic signed [skalk_pkg::DATA_W-1:0]  sample_z,
  input  logic                                 restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [skalk_pkg::DATA_W-1:0]  estimate_x,
  output logic signed [skalk_pkg::DATA_W-1:0]  estimate_y,
  output logic signed [skalk_pkg::DATA_W-1:0]  estimate_z,
  output logic        [skalk_pkg::GAIN_W-1:0]  gain_used,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [skalk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [skalk_pkg::DATA_W-1:0]  cfg_data
);
  import skalk_pkg::*;

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(NOISE_W - 1);
  localparam logic [STEP_W-1:0] GAIN_LAST = STEP_W'(GAIN_W - 1);
  localparam int SQ_W = 2 * NOISE_W;
  localparam int RW   = SQ_W + 2;
  localparam int VP_W = DATA_W + 1 + GAIN_W;
  localparam int VN_W = DATA_W + 2;

  // variance after reset, from the register defaults
  localparam logic [RW-1:0] RST_SQ = RW'(RST_INIT_DEV) * RW'(RST_INIT_DEV);
  localparam logic [RW-1:0] RST_VAR_W =
    ((RST_SQ + (RW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS) + RW'(RST_PROC_NOISE);
  localparam logic [DATA_W-1:0] RST_VAR =
    (|RST_VAR_W[RW-1:DATA_W]) ? '1 : RST_VAR_W[DATA_W-1:0];

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SQR  = 8'b0000_0010,
    ST_LOAD = 8'b0000_0100,
    ST_PREP = 8'b0000_1000,
    ST_DIV  = 8'b0001_0000,
    ST_MST  = 8'b0010_0000,
    ST_MUL  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   cnt;
  logic                in_acc;
  logic                fin_go;

  logic [NOISE_W-1:0]  process_noise;
  logic [NOISE_W-1:0]  measurement_noise;
  logic [NOISE_W-1:0]  initial_deviation;
  logic [DATA_W-1:0]   initial_estimate;

  logic [DATA_W-1:0]   var_q;
  logic [GAIN_W-1:0]   gain;
  logic [GAIN_W-1:0]   gain_q;

  mac_ctl_t            sq_ctl;
  mac_ctl_t            mul_ctl;
  div_ctl_t            div_ctl;

  logic signed [SQ_W:0]   sq_prod;
  logic [RW-1:0]          rv_sum;
  logic [RW-1:0]          rv_wide;
  logic [DATA_W-1:0]      rv_sat;

  logic signed [VP_W-1:0] vprod;
  logic [VP_W-1:0]        vrnd;
  logic [VN_W-1:0]        vn;
  logic [DATA_W-1:0]      vn_sat;

  logic signed [DATA_W-1:0] smp_in  [MAX_AXES];
  logic signed [DATA_W-1:0] est_res [MAX_AXES];

  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign fin_go    = (state == ST_FIN) && (!out_valid || out_ready);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= RST_PROC_NOISE;
      measurement_noise <= RST_MEAS_NOISE;
      initial_deviation <= RST_INIT_DEV;
      initial_estimate  <= RST_INIT_EST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PROC_NOISE: process_noise     <= cfg_data[NOISE_W-1:0];
        CFG_MEAS_NOISE: measurement_noise <= cfg_data[NOISE_W-1:0];
        CFG_INIT_DEV:   initial_deviation <= cfg_data[NOISE_W-1:0];
        CFG_INIT_EST:   initial_estimate  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: square on restart, divide, multiply, write back
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_acc) state <= restart ? ST_SQR : ST_PREP;
        end
        ST_SQR: begin
          cnt <= cnt + STEP_W'(1);
          if (cnt == SQ_LAST) state <= ST_LOAD;
        end
        ST_LOAD: state <= ST_PREP;
        ST_PREP: begin
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + STEP_W'(1);
          if (cnt == GAIN_LAST) state <= ST_MST;
        end
        ST_MST: begin
          cnt   <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          cnt <= cnt + STEP_W'(1);
          if (cnt == GAIN_LAST) state <= ST_FIN;
        end
        ST_FIN: if (fin_go) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // restart variance: square the deviation serially
  assign sq_ctl.start = in_acc & restart;
  assign sq_ctl.step  = (state == ST_SQR);

  skalk_mac #(.MW(NOISE_W + 1), .NB(NOISE_W)) u_sq (
    .clk  (clk),
    .ctl  (sq_ctl),
    .a    ({1'b0, initial_deviation}),
    .b    (initial_deviation),
    .prod (sq_prod)
  );

  // round off the fraction, add Q, saturate
  assign rv_sum  = RW'(sq_prod[SQ_W-1:0]) + (RW'(1) << (FRAC_BITS - 1));
  assign rv_wide = (rv_sum >> FRAC_BITS) + RW'(process_noise);
  assign rv_sat  = (|rv_wide[RW-1:DATA_W]) ? '1 : rv_wide[DATA_W-1:0];

  // gain = P / (P + R)
  assign div_ctl.start = (state == ST_PREP);
  assign div_ctl.step  = (state == ST_DIV);
  assign div_ctl.first = (cnt == '0);

  skalk_div u_div (
    .clk (clk),
    .ctl (div_ctl),
    .num (var_q),
    .den ({1'b0, var_q} + (DATA_W + 1)'(measurement_noise)),
    .quo (gain)
  );

  // the variance and estimate multiply lanes run together
  assign mul_ctl.start = (state == ST_MST);
  assign mul_ctl.step  = (state == ST_MUL);

  // variance update: (1 - gain) * P, rounded, plus Q
  skalk_mac #(.MW(DATA_W + 1), .NB(GAIN_W)) u_var (
    .clk  (clk),
    .ctl  (mul_ctl),
    .a    ({1'b0, var_q}),
    .b    (GAIN_ONE - gain),
    .prod (vprod)
  );

  assign vrnd   = vprod + (VP_W'(1) << (GAIN_BITS - 1));
  assign vn     = VN_W'(vrnd >> GAIN_BITS) + VN_W'(process_noise);
  assign vn_sat = (|vn[VN_W-1:DATA_W]) ? '1 : vn[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      var_q <= RST_VAR;
    end else if (state == ST_LOAD) begin
      var_q <= rv_sat;
    end else if (fin_go) begin
      var_q <= vn_sat;
    end
  end

  assign smp_in[0] = sample_x;
  assign smp_in[1] = sample_y;
  assign smp_in[2] = sample_z;

  // per-axis estimate lanes
  for (genvar i = 0; i < MAX_AXES; i++) begin : g_axis
    if (i < AXES) begin : g_on
      logic signed [DATA_W-1:0] smp_q;
      logic signed [DATA_W-1:0] est_q;
      logic signed [DATA_W-1:0] res_q;
      logic signed [DATA_W-1:0] est_new;
      logic signed [DATA_W:0]   diff;
      logic signed [VP_W-1:0]   aprod;
      logic        [VP_W-1:0]   arnd;

      // hold the sample for the whole update
      always_ff @(posedge clk) begin
        if (in_acc) smp_q <= smp_in[i];
      end

      assign diff = {smp_q[DATA_W-1], smp_q} - {est_q[DATA_W-1], est_q};

      skalk_mac #(.MW(DATA_W + 1), .NB(GAIN_W)) u_mac (
        .clk  (clk),
        .ctl  (mul_ctl),
        .a    (diff),
        .b    (gain),
        .prod (aprod)
      );

      // round half up and move the estimate toward the sample
      assign arnd    = aprod + (VP_W'(1) << (GAIN_BITS - 1));
      assign est_new = est_q + arnd[GAIN_BITS+DATA_W-1:GAIN_BITS];

      always_ff @(posedge clk) begin
        if (rst) begin
          est_q <= RST_INIT_EST;
        end else if (state == ST_LOAD) begin
          est_q <= initial_estimate;
        end else if (fin_go) begin
          est_q <= est_new;
        end
      end

      always_ff @(posedge clk) begin
        if (fin_go) res_q <= est_new;
      end

      assign est_res[i] = res_q;
    end else begin : g_off
      assign est_res[i] = '0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) gain_q <= gain;
  end

  assign estimate_x = est_res[0];
  assign estimate_y = est_res[1];
  assign estimate_z = est_res[2];
  assign gain_used  = gain_q;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an update was running");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gain_used <= GAIN_ONE))
    else $error("gain above one");

  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt <= GAIN_LAST))
    else $error("divider step count overran");

  a_unused_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (AXES > 2 || estimate_z == '0))
    else $error("unused axis estimate not zero");

  a_writeback: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> (out_valid && in_ready))
    else $error("write back did not publish the result");

endmodule
